/* hdl/vsc_pkg.sv */
`default_nettype none

package vsc_pkg;

    localparam int SIZE_XZ = 16;
    localparam int SIZE_Y  = 64;

    localparam int YW         = $clog2(SIZE_Y);
    localparam int BANK_XZ    = (SIZE_XZ + 1) / 2;
    localparam int BANK_DEPTH = BANK_XZ * BANK_XZ;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NUM_BANKS  = 4;
    localparam int QDEPTH     = 2;
    localparam int QCW        = $clog2(QDEPTH + 1);

    localparam logic [1:0] BANK_XBIT = 2'b10;
    localparam logic [1:0] BANK_ZBIT = 2'b01;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TEST  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic [AW-1:0]     addr_t;
    typedef logic [SIZE_Y-1:0] row_t;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          err;
        logic          fill;
        logic [YW-1:0] y;
        logic          y_lo_ok;
        logic          y_hi_ok;
        logic          xm_ok;
        logic          xp_ok;
        logic          zm_ok;
        logic          zp_ok;
        logic [1:0]    bank_c;
        addr_t         addr_c;
        addr_t         addr_xm;
        addr_t         addr_xp;
        addr_t         addr_zm;
        addr_t         addr_zp;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Rows are columns along y; the four banks are chosen by the low bits of x and z.
    function automatic addr_t row_addr(input logic [6:0] xc, input logic [6:0] zc);
        logic [12:0] sum;
        sum = 13'(xc[6:1]) * 13'(BANK_XZ) + 13'(zc[6:1]);
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/vsc_if.sv */
`default_nettype none

interface vsc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic signed [7:0] x_coord;
    logic signed [7:0] y_coord;
    logic signed [7:0] z_coord;
    logic              fill_value;

    modport source (output valid, command, x_coord, y_coord, z_coord, fill_value,
                    input ready);
    modport sink (input valid, command, x_coord, y_coord, z_coord, fill_value,
                  output ready);
endinterface

interface vsc_out_if;
    logic valid;
    logic ready;
    logic occupied;
    logic visible;
    logic range_error;
    logic rebuild_pending;

    modport source (output valid, occupied, visible, range_error, rebuild_pending,
                    input ready);
    modport sink (input valid, occupied, visible, range_error, rebuild_pending,
                  output ready);
endinterface

`default_nettype wire

/* hdl/vsc_front.sv */
`default_nettype none

module vsc_front
    import vsc_pkg::*;
(
    vsc_in_if.sink             request,
    input  q_status_t          q_status,
    input  back_status_t       b_status,
    output logic               push,
    output item_t              push_item
);

    logic       x_ok;
    logic       y_ok;
    logic       z_ok;
    logic       in_chunk;
    logic [6:0] xs;
    logic [6:0] ys;
    logic [6:0] zs;
    logic [6:0] xm;
    logic [6:0] xp;
    logic [6:0] zm;
    logic [6:0] zp;

    assign request.ready = !q_status.full && !b_status.clearing;
    assign push          = request.valid && request.ready;

    always_comb
    begin
        x_ok = !request.x_coord[7] && ({2'b00, request.x_coord[6:0]} < 9'(SIZE_XZ));
        y_ok = !request.y_coord[7] && ({2'b00, request.y_coord[6:0]} < 9'(SIZE_Y));
        z_ok = !request.z_coord[7] && ({2'b00, request.z_coord[6:0]} < 9'(SIZE_XZ));
        in_chunk = x_ok && y_ok && z_ok;

        xs = in_chunk ? request.x_coord[6:0] : 7'd0;
        ys = in_chunk ? request.y_coord[6:0] : 7'd0;
        zs = in_chunk ? request.z_coord[6:0] : 7'd0;

        push_item.cmd     = request.command;
        push_item.err     = ((request.command == CMD_WRITE) || (request.command == CMD_TEST))
                            && !in_chunk;
        push_item.fill    = request.fill_value;
        push_item.y       = ys[YW-1:0];
        push_item.y_lo_ok = (ys != 7'd0);
        push_item.y_hi_ok = (ys != 7'(SIZE_Y - 1));
        push_item.xm_ok   = (xs != 7'd0);
        push_item.xp_ok   = (xs != 7'(SIZE_XZ - 1));
        push_item.zm_ok   = (zs != 7'd0);
        push_item.zp_ok   = (zs != 7'(SIZE_XZ - 1));
        push_item.bank_c  = {xs[0], zs[0]};

        xm = push_item.xm_ok ? xs - 7'd1 : xs;
        xp = push_item.xp_ok ? xs + 7'd1 : xs;
        zm = push_item.zm_ok ? zs - 7'd1 : zs;
        zp = push_item.zp_ok ? zs + 7'd1 : zs;

        push_item.addr_c  = row_addr(xs, zs);
        push_item.addr_xm = row_addr(xm, zs);
        push_item.addr_xp = row_addr(xp, zs);
        push_item.addr_zm = row_addr(xs, zm);
        push_item.addr_zp = row_addr(xs, zp);
    end

endmodule

`default_nettype wire

/* hdl/vsc_queue.sv */
`default_nettype none

module vsc_queue
    import vsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head,
    output q_status_t q_status
);

    item_t              slot_reg [QDEPTH];
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCW'(QDEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/vsc_back.sv */
`default_nettype none

module vsc_back
    import vsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_status_t    q_status,
    input  item_t        head,
    output logic         pop,
    output back_status_t b_status,
    vsc_out_if.source    response
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_ISSUE = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    addr_t         clr_cnt_reg;
    addr_t         clr_cnt_next;
    logic          flag_reg;
    logic          flag_next;
    item_t         cur_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          occ_reg;
    logic          vis_reg;
    logic          err_reg;

    row_t          mem [NUM_BANKS][BANK_DEPTH];
    row_t          rd0 [NUM_BANKS];
    row_t          rd1 [NUM_BANKS];
    addr_t         raddr0 [NUM_BANKS];
    addr_t         raddr1 [NUM_BANKS];
    logic          wen [NUM_BANKS];
    addr_t         waddr;
    row_t          wdata;

    logic          go;
    row_t          center;
    row_t          row_xm;
    row_t          row_xp;
    row_t          row_zm;
    row_t          row_zp;
    row_t          new_row;
    logic [YW-1:0] y_m;
    logic [YW-1:0] y_p;
    logic          c_bit;
    logic          buried;
    logic          occ_next;
    logic          vis_next;
    logic          err_next;

    assign pop               = (state_reg == ST_ISSUE) && !q_status.empty;
    assign go                = (state_reg == ST_EVAL) && (!out_valid_reg || response.ready);
    assign b_status.clearing = (state_reg == ST_CLEAR);

    assign response.valid           = out_valid_reg;
    assign response.occupied        = occ_reg;
    assign response.visible         = vis_reg;
    assign response.range_error     = err_reg;
    assign response.rebuild_pending = flag_reg;

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        always_comb
        begin
            if (2'(b) == head.bank_c)
            begin
                raddr0[b] = head.addr_c;
                raddr1[b] = head.addr_c;
            end
            else if (2'(b) == (head.bank_c ^ BANK_XBIT))
            begin
                raddr0[b] = head.addr_xm;
                raddr1[b] = head.addr_xp;
            end
            else if (2'(b) == (head.bank_c ^ BANK_ZBIT))
            begin
                raddr0[b] = head.addr_zm;
                raddr1[b] = head.addr_zp;
            end
            else
            begin
                raddr0[b] = '0;
                raddr1[b] = '0;
            end

            wen[b] = (state_reg == ST_CLEAR)
                     || (go && (cur_reg.cmd == CMD_WRITE) && !cur_reg.err
                         && (2'(b) == cur_reg.bank_c));
        end

        always_ff @(posedge clk)
        begin
            if (wen[b])
            begin
                mem[b][waddr] <= wdata;
            end
            if (pop)
            begin
                rd0[b] <= mem[b][raddr0[b]];
                rd1[b] <= mem[b][raddr1[b]];
            end
        end
    end

    always_comb
    begin
        center = rd0[cur_reg.bank_c];
        row_xm = rd0[cur_reg.bank_c ^ BANK_XBIT];
        row_xp = rd1[cur_reg.bank_c ^ BANK_XBIT];
        row_zm = rd0[cur_reg.bank_c ^ BANK_ZBIT];
        row_zp = rd1[cur_reg.bank_c ^ BANK_ZBIT];
        y_m    = cur_reg.y - 1'b1;
        y_p    = cur_reg.y + 1'b1;
        c_bit  = center[cur_reg.y];

        // A neighbor outside the chunk counts as occupied.
        buried = (!cur_reg.xm_ok || row_xm[cur_reg.y])
                 && (!cur_reg.xp_ok || row_xp[cur_reg.y])
                 && (!cur_reg.zm_ok || row_zm[cur_reg.y])
                 && (!cur_reg.zp_ok || row_zp[cur_reg.y])
                 && (cur_reg.y_lo_ok ? center[y_m] : 1'b1)
                 && (cur_reg.y_hi_ok ? center[y_p] : 1'b1);

        new_row              = center;
        new_row[cur_reg.y]   = cur_reg.fill;

        waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : cur_reg.addr_c;
        wdata = (state_reg == ST_CLEAR) ? '0 : new_row;

        occ_next  = 1'b0;
        vis_next  = 1'b0;
        err_next  = 1'b0;
        flag_next = flag_reg;
        case (cur_reg.cmd)
            CMD_WRITE:
            begin
                err_next = cur_reg.err;
                if (!cur_reg.err && (c_bit != cur_reg.fill))
                begin
                    flag_next = 1'b1;
                end
            end
            CMD_TEST:
            begin
                err_next = cur_reg.err;
                if (!cur_reg.err)
                begin
                    occ_next = c_bit;
                    vis_next = c_bit && !buried;
                end
            end
            CMD_CLEAR:
            begin
                flag_next = 1'b0;
            end
            default:
            begin
                flag_next = flag_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(BANK_DEPTH - 1))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (pop)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (go)
                begin
                    state_next = ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (go)
            begin
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (go)
        begin
            occ_reg <= occ_next;
            vis_reg <= vis_next;
            err_reg <= err_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/voxel_surface_cull_top.sv */
// Voxel chunk occupancy map with six-neighbor face culling.
// The request channel carries one command per item: write a voxel, test a
// voxel, or clear the rebuild flag. The response channel returns exactly one
// item per request, in order, with occupied, visible, range_error and the
// rebuild flag as it stands after the command.
// A request enters a two-entry queue behind the decoder. The back end reads
// the voxel's column and its four side columns from four banks at once into
// its read registers, then evaluates, writes the column back for a write
// command and loads the output register once it is empty or being read.
// The back end pops a new item from the queue only after it has loaded the
// result of the last one into the output register.
// After reset the banks are swept to zero, one row per bank per cycle, over
// all BANK_DEPTH rows of each bank (64 for a 16 by 64 by 16 chunk);
// request.ready stays low during the sweep. The rebuild flag resets to zero.
// When the receiver stalls, the result waits in the output register, the
// back end holds its next item and the queue fills; request.ready drops once
// the queue is full.
`default_nettype none

module voxel_surface_cull_top
    import vsc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    vsc_in_if.sink     request,
    vsc_out_if.source  response
);

    logic         push;
    logic         pop;
    item_t        push_item;
    item_t        head;
    q_status_t    q_status;
    back_status_t b_status;

    vsc_front u_front (
        .request   (request),
        .q_status  (q_status),
        .b_status  (b_status),
        .push      (push),
        .push_item (push_item)
    );

    vsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    vsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .b_status (b_status),
        .response (response)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("item pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("item popped from an empty queue");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.clearing |-> !(request.valid && request.ready))
        else $error("item accepted during the clearing sweep");

    a_pop_then_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !pop)
        else $error("back end popped on two consecutive cycles");
`endif

endmodule

`default_nettype wire
